/* rtl/band_limited_step_decimator_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the step decimator. Each macro expects clk and rst_n
// in scope and is disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BAND_LIMITED_STEP_DECIMATOR_UNIT_ASSERT_SVH
`define BAND_LIMITED_STEP_DECIMATOR_UNIT_ASSERT_SVH

// Condition holds at every clock edge
`define BLSD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define BLSD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define BLSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/blsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsd_pkg
// Shared constants, types and helpers of the step decimator.
// ----------------------------------------------------------------------------
package blsd_pkg;

    localparam int MAX_TAPS        = 65;
    localparam int MAX_PHASES      = 64;
    localparam int OUT_DEPTH       = 1024;
    localparam int RING_SIZE       = 2048;
    localparam int COEF_DEPTH      = MAX_PHASES * MAX_TAPS;

    localparam int RING_AW         = $clog2(RING_SIZE);
    localparam int COEF_AW         = $clog2(COEF_DEPTH);
    localparam int LOG2_MAX_PHASES = $clog2(MAX_PHASES);
    localparam int DFAC_W          = LOG2_MAX_PHASES + 1;
    localparam int TAP_W           = 7;
    localparam int LG_W            = 3;
    localparam int PHASE_W         = 17;
    localparam int CALC_W          = PHASE_W + 1;
    localparam int CNT_W           = 11;
    localparam int ACC_W           = 40;
    localparam int SAMPLE_W        = 16;
    localparam int COEF_W          = 24;
    localparam int DELTA_W         = SAMPLE_W + 1;
    localparam int PROD_W          = DELTA_W + COEF_W;
    localparam int PROD_SHIFT      = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 7;
    localparam int STATUS_W        = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DECIM_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS       = 2'd1;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_COEF = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_EMPTY    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_MAC,
        S_DRAIN,
        S_POP_ACC,
        S_POP_OUT,
        S_RESP
    } fsm_t;

    // Requests from the sequencer to the accumulation ring
    typedef struct packed {
        logic               rd_en;
        logic               mac;
        logic [RING_AW-1:0] rd_addr;
        logic               zero_en;
        logic [RING_AW-1:0] zero_addr;
    } ring_cmd_t;

    // Occupancy of the ring's multiply-accumulate pipeline
    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
    } ring_stat_t;

    // Scale an integrator value by 2^-(8+lg) with floor, saturate to Q1.15
    function automatic logic signed [SAMPLE_W-1:0] scale_sat(
        input logic signed [ACC_W-1:0] acc,
        input logic [LG_W-1:0]         lg
    );
        logic signed [ACC_W-1:0] sh;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(32767);
        lo = ACC_W'(-32768);
        sh = acc >>> (PROD_SHIFT + int'(lg));
        if (sh > hi)
            return SAMPLE_W'(hi);
        else if (sh < lo)
            return SAMPLE_W'(lo);
        else
            return SAMPLE_W'(sh);
    endfunction

endpackage

/* rtl/blsd_ring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsd_ring
// Accumulation ring memory with its multiply-accumulate pipeline: read slot,
// multiply step by coefficient, add and write the slot back.
// ----------------------------------------------------------------------------
module blsd_ring
    import blsd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ring_cmd_t                  cmd,
    input  logic signed [DELTA_W-1:0]  delta,
    input  logic signed [COEF_W-1:0]   coef,
    output logic [ACC_W-1:0]           rd_data,
    output ring_stat_t                 stat
);

    logic [ACC_W-1:0]         ring_mem [RING_SIZE];
    logic [ACC_W-1:0]         rd_q_reg;
    logic                     s1_valid_reg;
    logic [RING_AW-1:0]       s1_addr_reg;
    logic                     s2_valid_reg;
    logic [RING_AW-1:0]       s2_addr_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         wb_data;

    // Add the floored product into the old slot value, wrapping at 40 bits
    assign wb_data = acc_reg + ACC_W'(prod_reg >>> PROD_SHIFT);

    // Write back accumulations or clear slots; read one slot
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
            ring_mem[s2_addr_reg] <= wb_data;
        else if (cmd.zero_en)
            ring_mem[cmd.zero_addr] <= '0;
        if (cmd.rd_en)
            rd_q_reg <= ring_mem[cmd.rd_addr];
    end

    // Advance the pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.rd_en && cmd.mac;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Multiply stage: hold slot value and product for the write-back
    always_ff @(posedge clk)
    begin
        s1_addr_reg <= cmd.rd_addr;
        s2_addr_reg <= s1_addr_reg;
        acc_reg     <= rd_q_reg;
        prod_reg    <= PROD_W'(delta) * PROD_W'(coef);
    end

    assign rd_data       = rd_q_reg;
    assign stat.s1_valid = s1_valid_reg;
    assign stat.s2_valid = s2_valid_reg;

endmodule

/* rtl/band_limited_step_decimator_unit.sv */
`timescale 1ns / 1ps
// Push with a changed sample: the tap loop issues one coefficient and ring read per cycle,
//   plus a two-stage write-back.
// Push with equal sample, rejected push, coefficient write, unused command: decode, then result.
// Pop: ring read, integrate and clear slot, scale, result.
// Result becomes valid in the same cycle the unit returns to idle; the output register holds it under stall.
// After reset a clearing pass zeroes the 2048-entry ring; no item is accepted meanwhile.
// ----------------------------------------------------------------------------
// band_limited_step_decimator_unit
// Polyphase step decimator: accumulates coefficient-weighted sample steps
// into a ring and pops integrated, scaled, saturated output samples.
// ----------------------------------------------------------------------------
module band_limited_step_decimator_unit
    import blsd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    // item channel
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic [1:0]                   command,
    input  logic signed [SAMPLE_W-1:0]   sample_in,
    input  logic [COEF_AW-1:0]           coef_addr,
    input  logic signed [COEF_W-1:0]     coef_data,
    // result channel
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [SAMPLE_W-1:0]   sample_out,
    output logic [STATUS_W-1:0]          status,
    output logic [CNT_W-1:0]             available,
    // configuration channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    `include "band_limited_step_decimator_unit_assert.svh"

    fsm_t                       state_reg, state_next;

    logic [LG_W-1:0]            decim_log2_reg;
    logic [TAP_W-1:0]           taps_reg;

    cmd_t                       cmd_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [COEF_AW-1:0]         addr_reg;
    logic signed [COEF_W-1:0]   cdata_reg;

    logic [PHASE_W-1:0]         phase_count_reg, phase_count_next;
    logic signed [SAMPLE_W-1:0] prev_sample_reg, prev_sample_next;
    logic [ACC_W-1:0]           running_sum_reg, running_sum_next;
    logic [RING_AW-1:0]         ring_head_reg, ring_head_next;
    logic [CNT_W-1:0]           ready_count_reg, ready_count_next;

    logic signed [DELTA_W-1:0]  delta_reg, delta_next;
    logic [COEF_AW-1:0]         coef_ptr_reg, coef_ptr_next;
    logic [RING_AW-1:0]         slot_ptr_reg, slot_ptr_next;
    logic [TAP_W-1:0]           tap_cnt_reg, tap_cnt_next;
    logic [RING_AW-1:0]         clr_cnt_reg, clr_cnt_next;

    logic [STATUS_W-1:0]        res_status_reg, res_status_next;
    logic signed [SAMPLE_W-1:0] res_sample_reg, res_sample_next;

    logic                       result_valid_reg, result_valid_next;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic [STATUS_W-1:0]        status_reg;
    logic [CNT_W-1:0]           available_reg;

    logic signed [COEF_W-1:0]   coef_mem [COEF_DEPTH];
    logic signed [COEF_W-1:0]   coef_q_reg;
    logic                       coef_we;
    logic                       coef_re;

    ring_cmd_t                  ring_cmd;
    ring_stat_t                 ring_stat;
    logic [ACC_W-1:0]           ring_rd_data;
    logic                       ring_busy;

    logic                       item_accept;
    logic                       out_load;
    logic                       out_free;
    logic [LG_W-1:0]            lg_eff;
    logic [TAP_W-1:0]           taps_eff;
    logic [DFAC_W-1:0]          dec_factor;
    logic [CALC_W-1:0]          next_phase;
    logic [CALC_W-1:0]          target;
    logic [CALC_W-1:0]          sub_phase_full;
    logic [LOG2_MAX_PHASES-1:0] sub_phase;

    // Clamp configuration to the supported range
    always_comb
    begin
        if (decim_log2_reg > LG_W'(LOG2_MAX_PHASES))
            lg_eff = LG_W'(LOG2_MAX_PHASES);
        else
            lg_eff = decim_log2_reg;
        if (taps_reg == '0)
            taps_eff = TAP_W'(1);
        else if (taps_reg > TAP_W'(MAX_TAPS))
            taps_eff = TAP_W'(MAX_TAPS);
        else
            taps_eff = taps_reg;
    end

    assign dec_factor     = DFAC_W'(1) << lg_eff;
    assign next_phase     = CALC_W'(phase_count_reg) + CALC_W'(1);
    assign target         = (next_phase + CALC_W'(dec_factor) - CALC_W'(1)) >> lg_eff;
    assign sub_phase_full = (target << lg_eff) - next_phase;
    assign sub_phase      = sub_phase_full[LOG2_MAX_PHASES-1:0];

    assign item_stall  = (state_reg != S_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign out_free    = !result_valid_reg || !result_stall;
    assign ring_busy   = ring_stat.s1_valid || ring_stat.s2_valid;
    assign cfg_ready   = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decim_log2_reg <= LG_W'(LOG2_MAX_PHASES);
            taps_reg       <= TAP_W'(MAX_TAPS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DECIM_LOG2: decim_log2_reg <= cfg_data[LG_W-1:0];
                REG_TAPS:       taps_reg       <= cfg_data[TAP_W-1:0];
                default:        ;
            endcase
        end
    end

    // Capture the item beat
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            cmd_reg    <= cmd_t'(command);
            sample_reg <= sample_in;
            addr_reg   <= coef_addr;
            cdata_reg  <= coef_data;
        end
    end

    // Coefficient memory: write on load command, read one tap per cycle
    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[addr_reg] <= cdata_reg;
        if (coef_re)
            coef_q_reg <= coef_mem[coef_ptr_reg];
    end

    blsd_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ring_cmd),
        .delta   (delta_reg),
        .coef    (coef_q_reg),
        .rd_data (ring_rd_data),
        .stat    (ring_stat)
    );

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            phase_count_reg  <= '0;
            prev_sample_reg  <= '0;
            running_sum_reg  <= '0;
            ring_head_reg    <= '0;
            ready_count_reg  <= '0;
            tap_cnt_reg      <= '0;
            clr_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_count_reg  <= phase_count_next;
            prev_sample_reg  <= prev_sample_next;
            running_sum_reg  <= running_sum_next;
            ring_head_reg    <= ring_head_next;
            ready_count_reg  <= ready_count_next;
            tap_cnt_reg      <= tap_cnt_next;
            clr_cnt_reg      <= clr_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Working and result payload registers
    always_ff @(posedge clk)
    begin
        delta_reg      <= delta_next;
        coef_ptr_reg   <= coef_ptr_next;
        slot_ptr_reg   <= slot_ptr_next;
        res_status_reg <= res_status_next;
        res_sample_reg <= res_sample_next;
        if (out_load)
        begin
            sample_out_reg <= res_sample_reg;
            status_reg     <= res_status_reg;
            available_reg  <= ready_count_reg;
        end
    end

    // Sequencer: next state, state updates and memory requests
    always_comb
    begin
        state_next        = state_reg;
        phase_count_next  = phase_count_reg;
        prev_sample_next  = prev_sample_reg;
        running_sum_next  = running_sum_reg;
        ring_head_next    = ring_head_reg;
        ready_count_next  = ready_count_reg;
        delta_next        = delta_reg;
        coef_ptr_next     = coef_ptr_reg;
        slot_ptr_next     = slot_ptr_reg;
        tap_cnt_next      = tap_cnt_reg;
        clr_cnt_next      = clr_cnt_reg;
        res_status_next   = res_status_reg;
        res_sample_next   = res_sample_reg;
        coef_we           = 1'b0;
        coef_re           = 1'b0;
        ring_cmd          = '0;
        out_load          = 1'b0;

        unique case (state_reg)
            // Zero the ring one slot per cycle
            S_CLEAR:
            begin
                ring_cmd.zero_en   = 1'b1;
                ring_cmd.zero_addr = clr_cnt_reg;
                clr_cnt_next       = clr_cnt_reg + RING_AW'(1);
                if (clr_cnt_reg == RING_AW'(RING_SIZE - 1))
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (item_accept)
                    state_next = S_EXEC;
            end

            // Decode the command and do the single-cycle parts
            S_EXEC:
            begin
                res_status_next = STAT_OK;
                res_sample_next = '0;
                state_next      = S_RESP;
                case (cmd_reg)
                    CMD_PUSH:
                    begin
                        if (target > CALC_W'(OUT_DEPTH))
                        begin
                            res_status_next = STAT_OVERFLOW;
                        end
                        else
                        begin
                            phase_count_next = PHASE_W'(next_phase);
                            ready_count_next = CNT_W'(target);
                            if (sample_reg != prev_sample_reg)
                            begin
                                delta_next = DELTA_W'(sample_reg) - DELTA_W'(prev_sample_reg);
                                prev_sample_next = sample_reg;
                                coef_ptr_next    = COEF_AW'(sub_phase) * COEF_AW'(taps_eff);
                                slot_ptr_next    = ring_head_reg + RING_AW'(target);
                                tap_cnt_next     = '0;
                                state_next       = S_MAC;
                            end
                        end
                    end
                    CMD_POP:
                    begin
                        if (ready_count_reg == '0)
                        begin
                            res_status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            ring_cmd.rd_en   = 1'b1;
                            ring_cmd.rd_addr = ring_head_reg;
                            state_next       = S_POP_ACC;
                        end
                    end
                    CMD_COEF:
                    begin
                        coef_we = (addr_reg < COEF_AW'(COEF_DEPTH));
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Issue one tap per cycle into the multiply-accumulate pipeline
            S_MAC:
            begin
                coef_re          = 1'b1;
                ring_cmd.rd_en   = 1'b1;
                ring_cmd.mac     = 1'b1;
                ring_cmd.rd_addr = slot_ptr_reg;
                coef_ptr_next    = coef_ptr_reg + COEF_AW'(1);
                slot_ptr_next    = slot_ptr_reg + RING_AW'(1);
                tap_cnt_next     = tap_cnt_reg + TAP_W'(1);
                if (tap_cnt_reg == taps_eff - TAP_W'(1))
                    state_next = S_DRAIN;
            end

            // Wait for the last write-back
            S_DRAIN:
            begin
                if (!ring_busy)
                    state_next = S_RESP;
            end

            // Integrate the oldest slot, clear it, advance the head
            S_POP_ACC:
            begin
                running_sum_next   = running_sum_reg + ring_rd_data;
                ring_cmd.zero_en   = 1'b1;
                ring_cmd.zero_addr = ring_head_reg;
                ring_head_next     = ring_head_reg + RING_AW'(1);
                ready_count_next   = ready_count_reg - CNT_W'(1);
                if (phase_count_reg >= PHASE_W'(dec_factor))
                    phase_count_next = phase_count_reg - PHASE_W'(dec_factor);
                else
                    phase_count_next = '0;
                state_next = S_POP_OUT;
            end

            // Scale and saturate the integrator
            S_POP_OUT:
            begin
                res_sample_next = scale_sat($signed(running_sum_reg), lg_eff);
                state_next      = S_RESP;
            end

            // Hand the result to the output register once it is free
            S_RESP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        result_valid_next = out_load || (result_valid_reg && result_stall);
    end

    assign result_valid = result_valid_reg;
    assign sample_out   = sample_out_reg;
    assign status       = status_reg;
    assign available    = available_reg;

    `BLSD_ASSERT_ALWAYS(a_ready_bound, ready_count_reg <= CNT_W'(OUT_DEPTH), "ready count above output depth")
    `BLSD_ASSERT_IMPLIES(a_drain_done, (state_reg == S_RESP) && ($past(state_reg) == S_DRAIN), !ring_busy, "result issued with write-back pending")
    `BLSD_ASSERT_IMPLIES(a_result_source, result_valid_reg && !$past(result_valid_reg), $past(state_reg) == S_RESP, "result beat raised outside response state")

endmodule
